// ----- hw/rtl/msf2f_pkg.sv -----
// Shared types and constants for the magnetic stripe F2F track encoder.
// No dependencies; used by every module of the encoder.
package msf2f_pkg;

    // command codes
    localparam logic [1:0] CMD_CHAR   = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_PAD    = 2'd2;

    // track formats
    localparam logic FMT_ALPHA   = 1'b0;
    localparam logic FMT_NUMERIC = 1'b1;

    // character offsets and widths per format
    localparam logic [7:0] OFFSET_ALPHA   = 8'd32;
    localparam logic [7:0] OFFSET_NUMERIC = 8'd48;
    localparam logic [5:0] BITS_ALPHA     = 6'd7;
    localparam logic [5:0] BITS_NUMERIC   = 6'd5;

    localparam int PATTERN_W = 7;
    localparam int COUNT_W   = 6;
    localparam int LRC_W     = 6;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // one queued job: bits to send LSB first and how many
    typedef struct packed {
        logic [PATTERN_W-1:0] bits;
        logic [COUNT_W-1:0]   count;
    } desc_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic nonempty;
    } q_status_t;

endpackage

// ----- hw/rtl/magstripe_f2f_track_encoder.sv -----
// Top level of the magnetic stripe track encoder with F2F line levels.
// Depends on msf2f_pkg, msf2f_front, msf2f_queue and msf2f_back.
//
// Each accepted word produces one output word per track bit: a character gives
// its data bits LSB first and an odd parity bit (7 words on track 1 format, 5
// on track 2/3 format), a finish gives the LRC character the same way and then
// clears the LRC, a pad gives pad_count zero bits, and command 3 or a zero pad
// gives nothing. The back serializer sends one bit per cycle while out_stall does
// not hold the output word, and items follow with no gap when the queue has one;
// the front accepts a word whenever the descriptor queue between them has room.
// The format register may be written at any time the encoder is idle.
module magstripe_f2f_track_encoder #(
    parameter int QueueDepth = msf2f_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] character,
    input  logic [5:0] pad_count,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       data_bit,
    output logic       first_half_level,
    output logic       second_half_level,
    output logic       last
);

    msf2f_pkg::q_status_t q_status;
    msf2f_pkg::desc_t     push_desc;
    msf2f_pkg::desc_t     head;
    logic                 push;
    logic                 pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_status.full;

    // command classifier
    msf2f_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .command   (command),
        .character (character),
        .pad_count (pad_count),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc)
    );

    // descriptor queue
    msf2f_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // bit serializer
    msf2f_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .q_status          (q_status),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .data_bit          (data_bit),
        .first_half_level  (first_half_level),
        .second_half_level (second_half_level),
        .last              (last)
    );

endmodule

// ----- hw/rtl/msf2f_queue.sv -----
// Small descriptor queue between the front classifier and the back serializer.
// Depends on msf2f_pkg for desc_t and q_status_t.
module msf2f_queue #(
    parameter int Depth = msf2f_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  msf2f_pkg::desc_t      push_desc,
    input  logic                  pop,
    output msf2f_pkg::desc_t      head,
    output msf2f_pkg::q_status_t  status
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    msf2f_pkg::desc_t entry_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  fill_reg, fill_next;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head            = entry_reg[rd_ptr_reg];
    assign status.full     = (fill_reg == CntW'(Depth));
    assign status.nonempty = (fill_reg != '0);

endmodule

// ----- hw/rtl/msf2f_front.sv -----
// Front end: accepts words, holds the format register and the LRC, and turns
// each command into a bit pattern descriptor. Depends on msf2f_pkg.
module msf2f_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_data,
    input  logic                  in_valid,
    input  logic [1:0]            command,
    input  logic [7:0]            character,
    input  logic [5:0]            pad_count,
    input  msf2f_pkg::q_status_t  q_status,
    output logic                  push,
    output msf2f_pkg::desc_t      push_desc
);

    logic                            track_format_reg;
    logic [msf2f_pkg::LRC_W-1:0]     lrc_reg, lrc_next;
    logic                            accept;
    logic [7:0]                      offset;
    logic [7:0]                      shifted;
    logic [msf2f_pkg::LRC_W-1:0]     char_value;
    logic [msf2f_pkg::LRC_W-1:0]     lrc_value;
    logic [msf2f_pkg::LRC_W-1:0]     value;
    logic                            parity;
    logic [msf2f_pkg::PATTERN_W-1:0] char_bits;
    logic [msf2f_pkg::COUNT_W-1:0]   char_count;
    logic                            has_bits;

    assign accept = in_valid && !q_status.full;

    // data bits of a character, masked to the format width
    always_comb
    begin
        offset  = (track_format_reg == msf2f_pkg::FMT_NUMERIC) ?
                  msf2f_pkg::OFFSET_NUMERIC : msf2f_pkg::OFFSET_ALPHA;
        shifted = character - offset;
        if (track_format_reg == msf2f_pkg::FMT_NUMERIC)
        begin
            char_value = {2'b00, shifted[3:0]};
            lrc_value  = {2'b00, lrc_reg[3:0]};
        end
        else
        begin
            char_value = shifted[5:0];
            lrc_value  = lrc_reg;
        end
    end

    // decode the command into a bit pattern
    always_comb
    begin
        value     = '0;
        lrc_next  = lrc_reg;
        push_desc = '0;
        has_bits  = 1'b0;
        unique case (command)
            msf2f_pkg::CMD_CHAR:
            begin
                value    = char_value;
                lrc_next = lrc_reg ^ char_value;
                has_bits = 1'b1;
            end
            msf2f_pkg::CMD_FINISH:
            begin
                value    = lrc_value;
                lrc_next = '0;
                has_bits = 1'b1;
            end
            msf2f_pkg::CMD_PAD:
            begin
                has_bits = (pad_count != '0);
            end
            default:
            begin
                has_bits = 1'b0;
            end
        endcase

        parity = ~(^value);
        if (track_format_reg == msf2f_pkg::FMT_NUMERIC)
        begin
            char_bits  = {2'b00, parity, value[3:0]};
            char_count = msf2f_pkg::BITS_NUMERIC;
        end
        else
        begin
            char_bits  = {parity, value};
            char_count = msf2f_pkg::BITS_ALPHA;
        end

        if (command == msf2f_pkg::CMD_PAD)
        begin
            push_desc.bits  = '0;
            push_desc.count = pad_count;
        end
        else
        begin
            push_desc.bits  = char_bits;
            push_desc.count = char_count;
        end
    end

    assign push = accept && has_bits;

    // format register and running lrc
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_format_reg <= msf2f_pkg::FMT_ALPHA;
            lrc_reg          <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                track_format_reg <= cfg_data;
            end
            if (accept)
            begin
                lrc_reg <= lrc_next;
            end
        end
    end

endmodule

// ----- hw/rtl/msf2f_back.sv -----
// Back end: shifts queued bit patterns out one bit per unstalled cycle, tracks
// the F2F line level and holds the output word register. Depends on msf2f_pkg.
module msf2f_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  msf2f_pkg::desc_t      head,
    input  msf2f_pkg::q_status_t  q_status,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  data_bit,
    output logic                  first_half_level,
    output logic                  second_half_level,
    output logic                  last
);

    logic [msf2f_pkg::PATTERN_W-1:0] shift_reg, shift_next;
    logic [msf2f_pkg::COUNT_W-1:0]   remaining_reg, remaining_next;
    logic                            level_reg, level_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            data_bit_reg, first_reg, second_reg, last_reg;
    logic                            active;
    logic                            out_free;
    logic                            emit;
    logic [msf2f_pkg::PATTERN_W-1:0] src_bits;
    logic [msf2f_pkg::COUNT_W-1:0]   src_count;
    logic                            bit_now;
    logic                            first_now;
    logic                            second_now;

    // pick the running job, or start the queue head in the same cycle
    always_comb
    begin
        active     = (remaining_reg != '0);
        out_free   = !out_valid_reg || !out_stall;
        src_bits   = active ? shift_reg : head.bits;
        src_count  = active ? remaining_reg : head.count;
        emit       = (active || q_status.nonempty) && out_free;
        pop        = emit && !active;
        bit_now    = src_bits[0];
        first_now  = ~level_reg;
        second_now = first_now ^ bit_now;

        shift_next     = emit ? (src_bits >> 1) : shift_reg;
        remaining_next = emit ? (src_count - 1'b1) : remaining_reg;
        level_next     = emit ? second_now : level_reg;
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            level_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        if (emit)
        begin
            data_bit_reg <= bit_now;
            first_reg    <= first_now;
            second_reg   <= second_now;
            last_reg     <= (src_count == msf2f_pkg::COUNT_W'(1));
        end
    end

    assign out_valid         = out_valid_reg;
    assign data_bit          = data_bit_reg;
    assign first_half_level  = first_reg;
    assign second_half_level = second_reg;
    assign last              = last_reg;

endmodule
